### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SITD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sitd assertion failed");

// next-cycle implication, disabled during reset
`define SITD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sitd assertion failed");

`endif

### hw/rtl/sitd_pkg.sv
// shared constants, types and helpers for the decimal text formatter
`timescale 1ns / 1ps
`default_nettype none

package sitd_pkg;

  // number of decimal digits in 2^(bits-1), the largest magnitude
  function automatic int dec_digits(input int bits);
    longint unsigned m;
    int n;
    m = 64'd1 << (bits - 1);
    n = 1;
    while (m >= 64'd10) begin
      m = m / 64'd10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int VALUE_BITS = 32;
  localparam int MAG_BITS   = VALUE_BITS + 1;
  localparam int ROUNDS     = (MAG_BITS + 3) / 4;
  localparam int PAD_BITS   = ROUNDS * 4;
  localparam int NDIG       = dec_digits(VALUE_BITS);
  localparam int BCD_BITS   = NDIG * 4;
  localparam int RND_W      = $clog2(ROUNDS);
  localparam int LZ_W       = $clog2(NDIG);
  localparam int CNT_W      = $clog2(NDIG + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic align;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic neg;
    logic rounds_done;
    logic digit_last;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/signed_int_to_decimal_ascii.sv
// top level: signed integer to decimal ascii character stream
// after start is accepted come 9 conversion rounds of four bits each, one alignment
//   step and one output register, then the text of 1 to 11 characters; a new word is
//   taken only after the last character of the previous one has been issued, as the
//   shared double-dabble shift register and one-character output port serve one word
//   at a time; reset: synchronous rst returns the controller to idle and clears the strobe
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [sitd_pkg::VALUE_BITS-1:0] value,
  output logic                                        valid,
  output logic [7:0]                                  char_code,
  output logic                                        is_last
);

  sitd_pkg::cmd_t    cmd;
  sitd_pkg::status_t status;

  // control sequencer
  sitd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .valid  (valid)
  );

  // conversion datapath
  sitd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .char_code (char_code),
    .is_last   (is_last)
  );

endmodule

`default_nettype wire

### hw/rtl/sitd_datapath.sv
// datapath: magnitude, double-dabble bcd conversion, alignment and char output
`timescale 1ns / 1ps
`default_nettype none

module sitd_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic signed [sitd_pkg::VALUE_BITS-1:0] value,
  input  wire sitd_pkg::cmd_t                      cmd,
  output sitd_pkg::status_t                        status,
  output logic [7:0]                               char_code,
  output logic                                     is_last
);

  logic [sitd_pkg::PAD_BITS-1:0] bin;
  logic [sitd_pkg::BCD_BITS-1:0] bcd;
  logic                          neg;
  logic [sitd_pkg::RND_W-1:0]    rnd;
  logic [sitd_pkg::CNT_W-1:0]    digits_left;

  logic [sitd_pkg::MAG_BITS-1:0] mag_w;
  logic [sitd_pkg::BCD_BITS-1:0] bcd_next;
  logic [sitd_pkg::PAD_BITS-1:0] bin_next;
  logic [sitd_pkg::LZ_W-1:0]     lz;
  logic [sitd_pkg::BCD_BITS-1:0] bcd_aligned;

  // magnitude one bit wider than the value
  always_comb begin
    if (value[sitd_pkg::VALUE_BITS-1]) begin
      mag_w = sitd_pkg::MAG_BITS'(0) - {value[sitd_pkg::VALUE_BITS-1], value};
    end else begin
      mag_w = {1'b0, value};
    end
  end

  // four double-dabble bit steps per cycle
  always_comb begin
    bcd_next = bcd;
    bin_next = bin;
    for (int b = 0; b < 4; b++) begin
      for (int d = 0; d < sitd_pkg::NDIG; d++) begin
        if (bcd_next[4*d +: 4] >= 4'd5) begin
          bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
        end
      end
      {bcd_next, bin_next} = {bcd_next[sitd_pkg::BCD_BITS-2:0], bin_next, 1'b0};
    end
  end

  // leading zero digits, keeping at least one digit
  always_comb begin
    int  cnt;
    logic found;
    cnt   = 0;
    found = 1'b0;
    for (int d = sitd_pkg::NDIG - 1; d >= 1; d--) begin
      if (!found && (bcd[4*d +: 4] == 4'd0)) begin
        cnt = cnt + 1;
      end else begin
        found = 1'b1;
      end
    end
    lz          = sitd_pkg::LZ_W'(cnt);
    bcd_aligned = bcd << {lz, 2'b00};
  end

  // conversion and emission registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd         <= '0;
      digits_left <= '0;
      neg         <= 1'b0;
    end else begin
      if (cmd.load) begin
        bin <= sitd_pkg::PAD_BITS'(mag_w);
        bcd <= '0;
        neg <= value[sitd_pkg::VALUE_BITS-1];
        rnd <= '0;
      end else if (cmd.conv_step) begin
        bin <= bin_next;
        bcd <= bcd_next;
        rnd <= rnd + 1'b1;
      end else if (cmd.align) begin
        bcd         <= bcd_aligned;
        digits_left <= sitd_pkg::CNT_W'(sitd_pkg::NDIG) - sitd_pkg::CNT_W'(lz);
      end else if (cmd.emit_sign) begin
        char_code <= sitd_pkg::CHAR_MINUS;
        is_last   <= 1'b0;
      end else if (cmd.emit_digit) begin
        char_code <= sitd_pkg::CHAR_ZERO + {4'b0000, bcd[sitd_pkg::BCD_BITS-1 -: 4]};
        is_last   <= (digits_left == sitd_pkg::CNT_W'(1));
        bcd       <= bcd << 4;
        digits_left <= digits_left - 1'b1;
      end
    end
  end

  // status back to the controller
  assign status.neg         = neg;
  assign status.rounds_done = (rnd == sitd_pkg::RND_W'(sitd_pkg::ROUNDS - 1));
  assign status.digit_last  = (digits_left == sitd_pkg::CNT_W'(1));

endmodule

`default_nettype wire

### hw/rtl/sitd_ctrl.sv
// controller: sequences load, conversion, alignment and character output
`timescale 1ns / 1ps
`default_nettype none

module sitd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire sitd_pkg::status_t status,
  output sitd_pkg::cmd_t         cmd,
  output logic                   busy,
  output logic                   valid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_ALIGN,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t state;

  // commands decoded from the current state, with load also gated by start in idle
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:  cmd.load       = start;
      ST_CONV:  cmd.conv_step  = 1'b1;
      ST_ALIGN: cmd.align      = 1'b1;
      ST_SIGN:  cmd.emit_sign  = 1'b1;
      ST_EMIT:  cmd.emit_digit = 1'b1;
      default:  cmd = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // state and registered strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= 1'b0;
    end else begin
      valid <= (state == ST_SIGN) || (state == ST_EMIT);
      case (state)
        ST_IDLE: begin
          if (start) state <= ST_CONV;
        end
        ST_CONV: begin
          if (status.rounds_done) state <= ST_ALIGN;
        end
        ST_ALIGN: begin
          state <= status.neg ? ST_SIGN : ST_EMIT;
        end
        ST_SIGN: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (status.digit_last) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sitd_checker.sv
// port-level checker for the decimal text formatter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sitd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       valid,
  input wire logic [7:0] char_code,
  input wire logic       is_last
);

  logic is_digit;
  logic is_minus;

  assign is_digit = (char_code >= sitd_pkg::CHAR_ZERO) && (char_code <= 8'd57);
  assign is_minus = (char_code == sitd_pkg::CHAR_MINUS);

  // every character is a minus sign or a digit
  `SITD_ASSERT_NOW(a_char_set, clk, rst, valid, is_digit || is_minus)
  // a minus sign never ends the text
  `SITD_ASSERT_NOW(a_sign_not_last, clk, rst, valid && is_minus, !is_last)
  // characters of one word come back to back
  `SITD_ASSERT_NEXT(a_run_contig, clk, rst, valid && !is_last, valid)
  // a gap follows the final character
  `SITD_ASSERT_NEXT(a_gap_after_last, clk, rst, valid && is_last, !valid)
  // an accepted word makes the block busy, with no character strobed yet
  `SITD_ASSERT_NEXT(a_busy_after_start, clk, rst, start && !busy, busy && !valid)

endmodule

bind signed_int_to_decimal_ascii sitd_checker u_sitd_checker (.*);

`default_nettype wire

### tb/tb_signed_int_to_decimal_ascii.sv
// testbench for the signed integer to decimal ascii formatter
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

  localparam int VB         = sitd_pkg::VALUE_BITS;
  localparam int MB         = sitd_pkg::MAG_BITS;
  localparam int RAND_WORDS = 330;
  localparam int MAX_CYCLES = 200000;
  localparam int DRAIN      = 30;

  // one expected character of a word's text
  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  // keeps the expected text of accepted words and checks every character
  class text_board;
    text_char_t pending_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    // appends the decimal text of an accepted word, most significant first
    function void note_word(logic signed [VB-1:0] word);
      logic [MB-1:0] mag;
      logic [3:0]    rev_digits[$];
      text_char_t    c;
      mag = {word[VB-1], word};
      if (word[VB-1]) begin
        mag = ~mag + 1'b1;
        c.code = sitd_pkg::CHAR_MINUS;
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      // digits come out least significant first
      do begin
        rev_digits.push_back(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      while (rev_digits.size() > 0) begin
        c.code = sitd_pkg::CHAR_ZERO + 8'(rev_digits.pop_back());
        c.last = (rev_digits.size() == 0);
        pending_chars.push_back(c);
      end
    endfunction

    // compares one strobed character with the oldest expectation
    function void check_char(logic [7:0] code, logic last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t unexpected character: expected none, actual code %0d last %0b",
                 $time, code, last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (code !== want.code) begin
        $display("%0t char_code mismatch: expected %0d, actual %0d", $time, want.code, code);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t is_last mismatch: expected %0b, actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic signed [VB-1:0] value;
  logic                 valid;
  logic [7:0]           char_code;
  logic                 is_last;

  text_board board = new();
  int        cycles = 0;

  signed_int_to_decimal_ascii dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .valid     (valid),
    .char_code (char_code),
    .is_last   (is_last)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("%0t timeout with %0d characters outstanding", $time, board.outstanding());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result monitor, the block cannot be held off
  always @(posedge clk) begin
    if (!rst && valid) begin
      board.check_char(char_code, is_last);
    end
  end

  // sends one word after a random gap, returns at the edge that accepts it
  task automatic send_word(input logic signed [VB-1:0] word);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= word;
    do @(posedge clk); while (busy);
    board.note_word(word);
  endtask

  // random word: full range, a chosen digit count, small values or near the ends
  function automatic logic signed [VB-1:0] pick_word();
    longint lo;
    longint hi;
    longint mag;
    logic   neg;
    int     ndig;
    neg = $urandom_range(0, 1);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        ndig = $urandom_range(1, 10);
        lo = (ndig == 1) ? 0 : 1;
        for (int i = 1; i < ndig; i++) lo = lo * 10;
        hi = (ndig == 1) ? 9 : lo * 10 - 1;
        mag = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
        if (neg && mag > 64'sd2147483648) mag = 64'sd2147483648;
        if (!neg && mag > 64'sd2147483647) mag = 64'sd2147483647;
        return neg ? VB'(-mag) : VB'(mag);
      end
      2: return VB'($signed($urandom_range(0, 200)) - 100);
      default: begin
        mag = $urandom_range(0, 20);
        return neg ? VB'(-64'sd2147483648 + mag) : VB'(64'sd2147483647 - mag);
      end
    endcase
  endfunction

  // stimulus
  initial begin
    logic signed [VB-1:0] edge_words[$];
    rst   = 1'b1;
    start = 1'b0;
    value = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // zero, single digits, digit count boundaries, both extremes, bit patterns
    edge_words = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -12345,
                   999999999, 1000000000, -999999999, -1000000000,
                   32'sh7fffffff, 32'sh7ffffffe, 32'sh80000000, 32'sh80000001,
                   32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f};
    foreach (edge_words[i]) send_word(edge_words[i]);

    for (int n = 0; n < RAND_WORDS; n++) begin
      // occasional bursts with no gaps at all
      if (n % 60 < 10) begin
        start <= 1'b1;
        value <= pick_word();
        do @(posedge clk); while (busy);
        board.note_word(value);
      end else begin
        send_word(pick_word());
      end
    end
    start <= 1'b0;

    // drain and watch for stray characters
    while (board.outstanding() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/sitd_pkg.sv
hw/rtl/sitd_datapath.sv
hw/rtl/sitd_ctrl.sv
hw/rtl/signed_int_to_decimal_ascii.sv
hw/rtl/sitd_checker.sv
tb/tb_signed_int_to_decimal_ascii.sv
